>>> hw/rtl/pipc_pkg.sv
// shared types and constants for the point-in-polygon crossing block
package pipc_pkg;

   localparam int unsigned ACTION_W = 2;
   localparam int unsigned RSP_W    = 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_QUERY  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic take;
      logic issue;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic issue_last;
      logic pipe_busy;
      logic rsp_full;
   } status_type;

endpackage

>>> hw/rtl/pipc_ctrl.sv
// controller state machine for the point-in-polygon crossing block
module pipc_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pipc_pkg::ACTION_W-1:0]      req_tuser,
   output pipc_pkg::cmd_type                  cmd,
   input  pipc_pkg::status_type               status
);
   import pipc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               if (req_tuser == ACT_QUERY) begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cmd.issue = 1'b1;
            if (status.issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!status.rsp_full) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/pipc_datapath.sv
// vertex store, edge walk pipeline and result register
module pipc_datapath #(
   parameter int unsigned MAX_VERTICES = 64,
   parameter int unsigned COORD_WIDTH  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [2*COORD_WIDTH-1:0]           req_word,
   input  logic [pipc_pkg::ACTION_W-1:0]      req_tuser,
   input  pipc_pkg::cmd_type                  cmd,
   output pipc_pkg::status_type               status,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pipc_pkg::RSP_W-1:0]         rsp_tdata
);
   import pipc_pkg::*;

   localparam int unsigned CW = COORD_WIDTH;
   localparam int unsigned DW = COORD_WIDTH + 1;
   localparam int unsigned PW = 2 * DW;
   localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int unsigned SW = $clog2(MAX_VERTICES + 1);

   logic [CW-1:0] in_x;
   logic [CW-1:0] in_y;
   assign in_x = req_word[CW-1:0];
   assign in_y = req_word[2*CW-1:CW];

   // vertex store
   logic [CW-1:0] mem_x_ff [MAX_VERTICES];
   logic [CW-1:0] mem_y_ff [MAX_VERTICES];

   logic [SW-1:0] count_ff;
   logic [SW-1:0] step_ff;
   logic [CW-1:0] px_ff;
   logic [CW-1:0] py_ff;
   logic [AW-1:0] rd_addr;
   logic          do_append;

   assign do_append = cmd.take && (req_tuser == ACT_APPEND) &&
                      (count_ff < SW'(MAX_VERTICES));

   // walk 0..count-1 then vertex 0 again for the closing edge
   assign rd_addr = (step_ff == count_ff) ? '0 : step_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (do_append) begin
         mem_x_ff[count_ff[AW-1:0]] <= in_x;
         mem_y_ff[count_ff[AW-1:0]] <= in_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.take && (req_tuser == ACT_CLEAR)) begin
         count_ff <= '0;
      end else if (do_append) begin
         count_ff <= count_ff + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && (req_tuser == ACT_QUERY)) begin
         px_ff <= in_x;
         py_ff <= in_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.take) begin
         step_ff <= '0;
      end else if (cmd.issue) begin
         step_ff <= step_ff + SW'(1);
      end
   end

   // stage 1: registered store read
   logic [CW-1:0] rd_x_ff;
   logic [CW-1:0] rd_y_ff;
   logic          v1_ff;
   logic          has_prev1_ff;
   logic [CW-1:0] prev_x_ff;
   logic [CW-1:0] prev_y_ff;

   always_ff @(posedge clock) begin
      rd_x_ff <= mem_x_ff[rd_addr];
      rd_y_ff <= mem_y_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         has_prev1_ff <= 1'b0;
      end else begin
         v1_ff        <= cmd.issue;
         has_prev1_ff <= cmd.issue && (step_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         prev_x_ff <= rd_x_ff;
         prev_y_ff <= rd_y_ff;
      end
   end

   // stage 2: edge test and cross products
   logic signed [DW-1:0] diff_a;
   logic signed [DW-1:0] diff_dy;
   logic signed [DW-1:0] diff_b;
   logic signed [DW-1:0] diff_c;
   logic                 above0;
   logic                 above1;

   assign diff_a  = $signed({px_ff[CW-1], px_ff}) - $signed({prev_x_ff[CW-1], prev_x_ff});
   assign diff_dy = $signed({rd_y_ff[CW-1], rd_y_ff}) - $signed({prev_y_ff[CW-1], prev_y_ff});
   assign diff_b  = $signed({rd_x_ff[CW-1], rd_x_ff}) - $signed({prev_x_ff[CW-1], prev_x_ff});
   assign diff_c  = $signed({py_ff[CW-1], py_ff}) - $signed({prev_y_ff[CW-1], prev_y_ff});
   assign above0  = $signed(prev_y_ff) > $signed(py_ff);
   assign above1  = $signed(rd_y_ff) > $signed(py_ff);

   logic signed [PW-1:0] prod_l_ff;
   logic signed [PW-1:0] prod_r_ff;
   logic                 v2_ff;
   logic                 crosses_ff;
   logic                 rising_ff;

   always_ff @(posedge clock) begin
      prod_l_ff <= PW'(diff_a) * PW'(diff_dy);
      prod_r_ff <= PW'(diff_b) * PW'(diff_c);
      // on a counting edge the upper end tells the sign of dy
      crosses_ff <= above0 != above1;
      rising_ff  <= above1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff && has_prev1_ff;
      end
   end

   // stage 3: parity
   logic parity_ff;
   logic left_of;

   assign left_of = rising_ff ? (prod_l_ff < prod_r_ff) : (prod_l_ff > prod_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= 1'b0;
      end else if (cmd.take) begin
         parity_ff <= 1'b0;
      end else if (v2_ff && crosses_ff && left_of) begin
         parity_ff <= ~parity_ff;
      end
   end

   // result register
   logic rsp_valid_ff;
   logic rsp_inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_inside_ff <= parity_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-1){1'b0}}, rsp_inside_ff};

   assign status.issue_last = step_ff == count_ff;
   assign status.pipe_busy  = v1_ff || v2_ff;
   assign status.rsp_full   = rsp_valid_ff && !rsp_tready;

endmodule

>>> hw/rtl/point_in_polygon_crossing.sv
// crossing-number point-in-polygon test: clear, append vertex, query
// clear and append words are taken in idle and give no response.
// a query walks the store once through its single read port, one vertex a cycle,
// then drains the read, cross-product and parity stages before the result loads.
// the word after a load is taken in the next cycle; a waiting response stalls only a finished query.
// synchronous reset empties the vertex list and drops any pending response; store contents are kept.
module point_in_polygon_crossing #(
   parameter int unsigned MAX_VERTICES = 64,
   parameter int unsigned COORD_WIDTH  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // coord_x, coord_y
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     req_tdata,
   // action
   input  logic [pipc_pkg::ACTION_W-1:0]          req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // inside_res
   output logic [pipc_pkg::RSP_W-1:0]             rsp_tdata
);
   import pipc_pkg::*;

   cmd_type    cmd;
   status_type status;

   pipc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status)
   );

   pipc_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_tdata[2*COORD_WIDTH-1:0]),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> hw/rtl/pipc_checker.sv
// port-level checks for the point-in-polygon crossing block, with bind
module pipc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [pipc_pkg::ACTION_W-1:0]      req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready
);
   import pipc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped before it was taken");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_no_rsp_for_edit: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != ACT_QUERY) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response produced by a non-query word");

   a_rsp_after_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response loaded while input was open");

endmodule

bind point_in_polygon_crossing pipc_checker u_pipc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
